>>> rtl/core/egm_pkg.sv
// ----------------------------------------------------------------------------
// Edge gradient magnitude package
// Shared constants and types for the gradient magnitude filter.
// ----------------------------------------------------------------------------
`default_nettype none

package egm_pkg;

    localparam int MaxWidth  = 1024;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int PixBits   = 16;
    localparam int MagBits   = 20;
    localparam int GradBits  = 20;
    localparam int SqBits    = 42;
    localparam int RootBits  = 21;

    localparam logic [19:0] MagMax = 20'd524287;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_SRC_ND = 3'd3,
        REG_RES_ND = 3'd4
    } reg_idx_t;

    // Classified work item passed from the window front to the magnitude back.
    typedef struct packed {
        logic                       valid_px;
        logic signed [GradBits-1:0] gx;
        logic signed [GradBits-1:0] gy;
        logic                       eof;
    } work_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQUARE,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/edge_gradient_magnitude_filter.sv
// ----------------------------------------------------------------------------
// Edge gradient magnitude filter
// Sobel or Roberts cross gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order: tdata carries the
// signed pixel, tuser marks a padding item. Each accepted pixel leaves one
// result on m_axis (tdata: magnitude, nodata flag, end of frame; tlast
// repeats end of frame) once its neighborhood is complete, width+1 items
// later, so the host appends width+1 padding items per frame.
// The front end reads two line-store RAMs and shifts a 3x3 window; a pixel
// waits in a stage for the registered RAM read, and no new pixel is taken
// while it waits. The back end squares the gradients and runs a bit-serial
// square root of 21 steps; the root loop sets the sustained rate.
// One stored work item lets the front run ahead of the back.
// Reset clears counters, window and registers (Sobel, width 1024, height 1);
// line stores need no clearing. A stalled receiver holds the result and
// back-pressures the input through the queue. Configuration must be
// written on the cfg channel only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_gradient_magnitude_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // pixel
    input  wire logic        s_axis_tuser,   // is_padding
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // magnitude, is_nodata, end_of_frame
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic                mode_reg;
    logic [10:0]         width_reg;
    logic [15:0]         height_reg;
    logic signed [15:0]  src_nd_reg, res_nd_reg;
    logic                wk_valid, wk_ready;
    egm_pkg::work_t      wk_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            width_reg  <= 11'd1024;
            height_reg <= 16'd1;
            src_nd_reg <= '0;
            res_nd_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                egm_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                egm_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                egm_pkg::REG_HEIGHT: height_reg <= cfg_data;
                egm_pkg::REG_SRC_ND: src_nd_reg <= cfg_data;
                egm_pkg::REG_RES_ND: res_nd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    egm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_pixel(s_axis_tdata), .in_pad(s_axis_tuser),
        .mode(mode_reg), .img_w(width_reg), .img_h(height_reg), .src_nd(src_nd_reg),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk_data(wk_data)
    );

    egm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk_data(wk_data),
        .res_nd(res_nd_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/egm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module egm_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/egm_front.sv
// ----------------------------------------------------------------------------
// Window front end
// Accepts pixels, keeps the line stores and window, computes gradients.
// ----------------------------------------------------------------------------
`default_nettype none

module egm_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [egm_pkg::PixBits-1:0] in_pixel,
    input  wire logic                               in_pad,
    input  wire logic                               mode,
    input  wire logic [10:0]                        img_w,
    input  wire logic [15:0]                        img_h,
    input  wire logic signed [15:0]                 src_nd,
    output logic                                    wk_valid,
    input  wire logic                               wk_ready,
    output egm_pkg::work_t                          wk_data
);

    localparam int CB = egm_pkg::ColBits;
    localparam int PB = egm_pkg::PixBits;
    localparam int GB = egm_pkg::GradBits;

    logic [10:0] w_eff;
    logic [15:0] h_eff;
    logic [CB-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [25:0]   emitted_reg, emitted_next;
    logic signed [PB-1:0] win_reg [3][3];
    logic          stg_reg;
    logic          stg_have_reg;
    logic [CB-1:0] stg_col_reg;
    logic [15:0]   stg_row_reg;
    logic signed [PB-1:0] stg_px_reg;
    logic          stg_eof_reg;
    logic          wk_valid_reg;
    egm_pkg::work_t wk_reg;
    logic signed [PB-1:0] up_q, lo_q;
    logic [CB-1:0] rd_col;
    logic          in_frame, take, step, adv;
    logic signed [PB-1:0] px_in;
    logic          have, eof_now;
    logic [CB-1:0] ocol;
    logic [15:0]   orow;
    logic signed [PB-1:0] p [3][3];
    logic          ok;
    logic signed [GB-1:0] gx, gy;
    logic [31:0]   total;

    always_comb
    begin
        w_eff = (img_w == 11'd0) ? 11'd1 :
                (img_w > 11'(egm_pkg::MaxWidth)) ? 11'(egm_pkg::MaxWidth) : img_w;
        h_eff = (img_h == 16'd0) ? 16'd1 : img_h;
    end

    // A stage holds the accepted pixel while the line store read completes.
    assign adv      = !stg_reg || !wk_valid_reg || wk_ready;
    assign in_ready = !stg_reg;
    assign in_frame = row_reg < h_eff;
    assign take     = in_valid && in_ready;
    assign step     = take && !(in_frame && in_pad);
    assign px_in    = in_frame ? in_pixel : '0;
    assign have     = (row_reg >= 16'd2) || (row_reg == 16'd1 && col_reg != '0);
    assign total    = 32'(w_eff) * 32'(h_eff);
    assign eof_now  = have && ({6'd0, emitted_reg} + 32'd1 >= total);

    // While the stage waits, keep reading its own column so the data holds.
    assign rd_col   = stg_reg ? stg_col_reg : col_reg;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        emitted_next = emitted_reg;
        if (step)
        begin
            if ({1'b0, col_reg} + 11'd1 >= w_eff)
            begin
                col_next = '0;
                row_next = row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (eof_now)
            begin
                col_next     = '0;
                row_next     = '0;
                emitted_next = '0;
            end
            else if (have)
            begin
                emitted_next = emitted_reg + 26'd1;
            end
        end
    end

    egm_ram #(.Width(PB), .Depth(egm_pkg::MaxWidth)) u_upper (
        .clk(clk), .wr_en(stg_reg && adv), .wr_addr(stg_col_reg), .wr_data(lo_q),
        .rd_addr(rd_col), .rd_data(up_q)
    );

    egm_ram #(.Width(PB), .Depth(egm_pkg::MaxWidth)) u_lower (
        .clk(clk), .wr_en(stg_reg && adv), .wr_addr(stg_col_reg), .wr_data(stg_px_reg),
        .rd_addr(rd_col), .rd_data(lo_q)
    );

    // Window as it stands after the staged pixel is shifted in.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            p[r][0] = win_reg[r][1];
            p[r][1] = win_reg[r][2];
        end
        p[0][2] = up_q;
        p[1][2] = lo_q;
        p[2][2] = stg_px_reg;
    end

    always_comb
    begin
        if (stg_col_reg != '0)
        begin
            orow = stg_row_reg - 16'd1;
            ocol = stg_col_reg - 1'b1;
        end
        else
        begin
            orow = stg_row_reg - 16'd2;
            ocol = CB'(w_eff - 11'd1);
        end
        if (!mode)
        begin
            ok = ({1'b0, orow} + 17'd1 < {1'b0, h_eff}) &&
                 ({1'b0, ocol} + 11'd1 < w_eff) &&
                 p[1][1] != src_nd && p[2][2] != src_nd &&
                 p[2][1] != src_nd && p[1][2] != src_nd;
            gx = GB'(p[1][1]) - GB'(p[2][2]);
            gy = GB'(p[2][1]) - GB'(p[1][2]);
        end
        else
        begin
            ok = orow != 16'd0 && ocol != '0 &&
                 ({1'b0, orow} + 17'd1 < {1'b0, h_eff}) &&
                 ({1'b0, ocol} + 11'd1 < w_eff);
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (!(r == 1 && c == 1) && p[r][c] == src_nd)
                    begin
                        ok = 1'b0;
                    end
                end
            end
            gy = GB'(p[2][0]) + (GB'(p[2][1]) <<< 1) + GB'(p[2][2])
               - GB'(p[0][0]) - (GB'(p[0][1]) <<< 1) - GB'(p[0][2]);
            gx = GB'(p[0][2]) + (GB'(p[1][2]) <<< 1) + GB'(p[2][2])
               - GB'(p[0][0]) - (GB'(p[1][0]) <<< 1) - GB'(p[2][0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            emitted_reg  <= '0;
            stg_reg      <= 1'b0;
            wk_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            emitted_reg <= emitted_next;
            if (stg_reg && adv && stg_have_reg)
            begin
                wk_valid_reg <= 1'b1;
            end
            else if (wk_ready)
            begin
                wk_valid_reg <= 1'b0;
            end
            if (stg_reg && adv)
            begin
                stg_reg <= 1'b0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        win_reg[r][c] <= p[r][c];
                    end
                end
            end
            else if (step)
            begin
                stg_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            stg_have_reg <= have;
            stg_col_reg  <= col_reg;
            stg_row_reg  <= row_reg;
            stg_px_reg   <= px_in;
            stg_eof_reg  <= eof_now;
        end
        if (stg_reg && adv && stg_have_reg)
        begin
            wk_reg.valid_px <= ok;
            wk_reg.gx       <= gx;
            wk_reg.gy       <= gy;
            wk_reg.eof      <= stg_eof_reg;
        end
    end

    assign wk_valid = wk_valid_reg;
    assign wk_data  = wk_reg;

endmodule

`default_nettype wire

>>> rtl/core/egm_back.sv
// ----------------------------------------------------------------------------
// Magnitude back end
// Squares the gradients and takes a bit-serial floor square root.
// ----------------------------------------------------------------------------
`default_nettype none

module egm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wk_valid,
    output logic                     wk_ready,
    input  wire egm_pkg::work_t      wk_data,
    input  wire logic signed [15:0]  res_nd,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [23:0]              out_data,
    output logic                     out_last
);

    localparam int SB = egm_pkg::SqBits;
    localparam int RB = egm_pkg::RootBits;
    localparam int GB = egm_pkg::GradBits;

    egm_pkg::back_state_t state_reg, state_next;
    egm_pkg::work_t  item_reg;
    logic [17:0]     ax_reg, ay_reg;
    logic [35:0]     sqx, sqy;
    logic [SB-1:0]   rem_reg;
    logic [RB-1:0]   root_reg;
    logic [4:0]      cnt_reg;
    logic [19:0]     mag_reg;
    logic            nd_reg;
    logic [SB+1:0]   acc_reg;
    logic [SB+1:0]   acc_sh;
    logic [SB+1:0]   t2;
    logic            fit;
    logic [RB-1:0]   root_fin;

    // Gradients stay below 2^18, so each square fits in 36 bits.
    assign sqx = ax_reg * ax_reg;
    assign sqy = ay_reg * ay_reg;

    // Restoring square root: two radicand bits and one root bit per cycle.
    always_comb
    begin
        acc_sh   = {acc_reg[SB-1:0], rem_reg[SB-1:SB-2]};
        t2       = {{(SB-RB){1'b0}}, root_reg, 2'b01};
        fit      = acc_sh >= t2;
        root_fin = {root_reg[RB-2:0], fit};
    end

    always_comb
    begin
        state_next = state_reg;
        wk_ready   = 1'b0;
        out_valid  = state_reg == egm_pkg::B_OUT;
        case (state_reg)
            egm_pkg::B_IDLE:   begin
                wk_ready = 1'b1;
                if (wk_valid) state_next = egm_pkg::B_SQUARE;
            end
            egm_pkg::B_SQUARE: state_next = egm_pkg::B_ROOT;
            egm_pkg::B_ROOT:   if (cnt_reg == 5'd0) state_next = egm_pkg::B_OUT;
            egm_pkg::B_OUT:    if (out_ready) state_next = egm_pkg::B_IDLE;
            default:           state_next = egm_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= egm_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            egm_pkg::B_IDLE:
            begin
                item_reg <= wk_data;
                ax_reg <= wk_data.gx[GB-1] ? 18'(-wk_data.gx) : 18'(wk_data.gx);
                ay_reg <= wk_data.gy[GB-1] ? 18'(-wk_data.gy) : 18'(wk_data.gy);
            end
            egm_pkg::B_SQUARE:
            begin
                rem_reg  <= SB'(sqx) + SB'(sqy);
                root_reg <= '0;
                acc_reg  <= '0;
                cnt_reg  <= 5'd20;
            end
            egm_pkg::B_ROOT:
            begin
                rem_reg  <= {rem_reg[SB-3:0], 2'b00};
                acc_reg  <= fit ? acc_sh - t2 : acc_sh;
                root_reg <= root_fin;
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    nd_reg  <= !item_reg.valid_px;
                    mag_reg <= item_reg.valid_px ?
                               ((root_fin > RB'(egm_pkg::MagMax)) ? egm_pkg::MagMax
                                : root_fin[19:0]) : 20'(res_nd);
                end
            end
            default: ;
        endcase
    end

    // The final step takes its root bit straight from the comparison, so the
    // captured magnitude holds the complete root, clamped to MagMax.
    assign out_data = {2'b00, item_reg.eof, nd_reg, mag_reg};
    assign out_last = item_reg.eof;

endmodule

`default_nettype wire

>>> rtl/core/egm_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the filter ports for stream and framing rules.
// ----------------------------------------------------------------------------
`default_nettype none

module egm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast == m_axis_tdata[21])
        else $error("tlast differs from end of frame");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("tdata padding not zero");

endmodule

bind edge_gradient_magnitude_filter egm_checker u_egm_checker (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

`default_nettype wire

>>> dv/tb_edge_gradient_magnitude_filter.sv
// ----------------------------------------------------------------------------
// Edge gradient magnitude filter testbench
// Streams raster frames through the filter in both operator modes and checks
// each result against a cycle-free predictor of the window, borders, missing
// pixel rules and integer square root. Covers size extremes, random frames,
// random idling on both streams and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_edge_gradient_magnitude_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LineDepth   = 1024;
    localparam int          StallLimit  = 5000;
    localparam int          SettleTicks = 60;
    localparam int          ItemTarget  = 1400;
    localparam logic [2:0]  RegUnused   = 3'd7;
    localparam logic        ModeRoberts = 1'b0;
    localparam logic        ModeSobel   = 1'b1;

    typedef struct {
        logic [15:0] pixel;
        logic        pad;
    } pixel_item_t;

    typedef struct {
        logic [19:0] magnitude;
        logic        nodata;
        logic        eof;
    } gradient_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // pixel
    logic        s_axis_tuser;   // is_padding
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // magnitude, is_nodata, end_of_frame
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    edge_gradient_magnitude_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_item_t pending_pixels[$];
    gradient_t   expected_gradients[$];

    // Shadow of the register file.
    logic               sh_mode;
    logic [10:0]        sh_width;
    logic [15:0]        sh_height;
    logic signed [15:0] sh_src_nd;
    logic signed [15:0] sh_res_nd;

    // Shadow of the neighborhood state.
    longint      upper_line[LineDepth];
    longint      lower_line[LineDepth];
    longint      win[3][3];
    int unsigned px_col;
    int unsigned px_row;
    int unsigned emitted;

    int  mismatches;
    int  results_seen;
    int  nodata_seen;
    int  frames_sent;
    int  items_sent;
    int  quiet_lo;
    int  quiet_hi;
    int  cycle_count;
    int  idle_cycles;
    bit  hold_done;
    int  hold_left;

    always #2 clk = ~clk;

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned grad_magnitude(longint gx, longint gy);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (ax > egm_pkg::MagMax || ay > egm_pkg::MagMax)
            return egm_pkg::MagMax;
        m = floor_root(ax * ax + ay * ay);
        return m > egm_pkg::MagMax ? egm_pkg::MagMax : m;
    endfunction

    task automatic predict_gradient(input logic [15:0] pixel, input logic pad);
        int unsigned w;
        int unsigned h;
        int unsigned ic;
        int unsigned ir;
        int unsigned orow;
        int unsigned ocol;
        longint      px;
        longint      nd;
        longint      gx;
        longint      gy;
        longint unsigned mag;
        bit          valid;
        gradient_t   g;
        w = sh_width;
        h = sh_height;
        if (w == 0)
            w = 1;
        if (w > LineDepth)
            w = LineDepth;
        if (h == 0)
            h = 1;
        if (px_row < h && pad)
            return;
        px = (px_row < h) ? longint'($signed(pixel)) : 0;
        ic = px_col;
        ir = px_row;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = upper_line[ic];
        win[1][2] = lower_line[ic];
        win[2][2] = px;
        upper_line[ic] = lower_line[ic];
        lower_line[ic] = px;
        if (ic + 1 >= w)
        begin
            px_col = 0;
            px_row = ir + 1;
        end
        else
            px_col = ic + 1;
        if (!(ir >= 2 || (ir == 1 && ic >= 1)))
            return;
        if (ic >= 1)
        begin
            orow = ir - 1;
            ocol = ic - 1;
        end
        else
        begin
            orow = ir - 2;
            ocol = w - 1;
        end
        nd = longint'(sh_src_nd);
        mag = 0;
        if (sh_mode == ModeRoberts)
        begin
            valid = (orow + 1 < h) && (ocol + 1 < w);
            if (valid)
            begin
                if (win[1][1] == nd || win[2][2] == nd || win[2][1] == nd || win[1][2] == nd)
                    valid = 0;
                else
                    mag = grad_magnitude(win[1][1] - win[2][2], win[2][1] - win[1][2]);
            end
        end
        else
        begin
            valid = orow > 0 && ocol > 0 && (orow + 1 < h) && (ocol + 1 < w);
            // The center pixel carries no weight, so it may be missing.
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (!(r == 1 && c == 1) && win[r][c] == nd)
                        valid = 0;
            if (valid)
            begin
                gy = win[2][0] + 2 * win[2][1] + win[2][2]
                   - (win[0][0] + 2 * win[0][1] + win[0][2]);
                gx = win[0][2] + 2 * win[1][2] + win[2][2]
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
                mag = grad_magnitude(gx, gy);
            end
        end
        g.magnitude = valid ? mag[19:0] : {{4{sh_res_nd[15]}}, sh_res_nd};
        g.nodata    = !valid;
        g.eof       = (longint'(emitted) + 1 >= longint'(w) * longint'(h));
        expected_gradients.insert(expected_gradients.size(), g);
        if (g.eof)
        begin
            px_col  = 0;
            px_row  = 0;
            emitted = 0;
        end
        else
            emitted++;
    endtask

    // Stimulus side: feeds pending pixels and predicts every accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_gradient(s_axis_tdata, s_axis_tuser);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() > 0 &&
                    ((cycle_count >= quiet_lo && cycle_count < quiet_hi) ||
                     $urandom_range(99) >= 12))
                begin
                    pixel_item_t it;
                    it = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= it.pixel;
                    s_axis_tuser  <= it.pad;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Register shadow follows every configuration transfer.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                egm_pkg::REG_MODE:   sh_mode   <= cfg_data[0];
                egm_pkg::REG_WIDTH:  sh_width  <= cfg_data[10:0];
                egm_pkg::REG_HEIGHT: sh_height <= cfg_data;
                egm_pkg::REG_SRC_ND: sh_src_nd <= cfg_data;
                egm_pkg::REG_RES_ND: sh_res_nd <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Receiver: random idling plus one long hold-off once results flow.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 100)
        begin
            hold_done     <= 1'b1;
            hold_left     <= 600;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (cycle_count >= quiet_lo && cycle_count < quiet_hi) ||
                             $urandom_range(99) >= 12;
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_gradients.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                gradient_t g;
                g = expected_gradients.pop_front();
                if (g.nodata)
                    nodata_seen++;
                if (m_axis_tdata[19:0] !== g.magnitude || m_axis_tdata[20] !== g.nodata ||
                    m_axis_tdata[21] !== g.eof || m_axis_tdata[23:22] !== 2'b00 ||
                    m_axis_tlast !== g.eof)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected mag=%h nodata=%b eof=%b, got tdata=%h tlast=%b",
                                 results_seen, g.magnitude, g.nodata, g.eof,
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        wait (pending_pixels.size() == 0 && !s_axis_tvalid && expected_gradients.size() == 0);
        repeat (SettleTicks) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_pixel(logic [15:0] nodata, logic [15:0] base);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return nodata;
        if (r < 10)
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        if (r < 50)
            return base + 16'($urandom_range(63)) - 16'd32;
        return 16'($urandom);
    endfunction

    // Queues one frame plus its drain items under a fresh register setting.
    task automatic run_frame(input logic mode, input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] src_nd, input logic [15:0] res_nd,
                             input bit extremes);
        int          ew;
        int          eh;
        logic [15:0] base;
        pixel_item_t it;
        wait_drained();
        write_reg(egm_pkg::REG_MODE, {15'd0, mode});
        write_reg(egm_pkg::REG_WIDTH, w);
        write_reg(egm_pkg::REG_HEIGHT, h);
        write_reg(egm_pkg::REG_SRC_ND, src_nd);
        write_reg(egm_pkg::REG_RES_ND, res_nd);
        ew = (w[10:0] == 0) ? 1 : (w[10:0] > LineDepth ? LineDepth : w[10:0]);
        eh = (h == 0) ? 1 : h;
        base = 16'($urandom);
        for (int i = 0; i < ew * eh; i++)
        begin
            // Padding inside the frame is dropped by the block.
            if ($urandom_range(99) < 4)
            begin
                it.pixel = 16'($urandom);
                it.pad   = 1'b1;
                pending_pixels.insert(pending_pixels.size(), it);
            end
            if (extremes)
                it.pixel = (i % 2 == 0) ? 16'h8000 : 16'h7FFF;
            else
                it.pixel = pick_pixel(src_nd, base);
            it.pad = 1'b0;
            pending_pixels.insert(pending_pixels.size(), it);
        end
        // Drain items may carry a pixel too; after the frame it is ignored.
        for (int i = 0; i <= ew; i++)
        begin
            it.pixel = 16'($urandom);
            it.pad   = $urandom_range(3) != 0;
            pending_pixels.insert(pending_pixels.size(), it);
        end
        items_sent += ew * eh + ew + 1;
        frames_sent++;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = egm_pkg::REG_MODE;
        cfg_data = '0;
        sh_mode = ModeSobel;
        sh_width = 11'd1024;
        sh_height = 16'd1;
        sh_src_nd = '0;
        sh_res_nd = '0;
        for (int i = 0; i < LineDepth; i++)
        begin
            upper_line[i] = 0;
            lower_line[i] = 0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = 0;
        px_col = 0;
        px_row = 0;
        emitted = 0;
        mismatches = 0;
        results_seen = 0;
        nodata_seen = 0;
        frames_sent = 0;
        items_sent = 0;
        cycle_count = 0;
        idle_cycles = 0;
        hold_done = 0;
        hold_left = 0;
        quiet_lo = 20000;
        quiet_hi = 26000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: opposite extremes in a small Sobel frame, then Roberts
        // with missing pixels and extreme nodata outputs.
        run_frame(ModeSobel, 16'd3, 16'd3, 16'h0000, 16'h7FFF, 1);
        run_frame(ModeRoberts, 16'd2, 16'd2, 16'h8000, 16'h8000, 1);
        run_frame(ModeRoberts, 16'd2, 16'd2, 16'h7FFF, 16'h1234, 0);
        // An unused register index must leave the setting alone.
        wait_drained();
        write_reg(RegUnused, 16'hFFFF);

        // Size extremes: zero, a wide row, a width whose register bits are
        // all zero, tall and narrow.
        run_frame(ModeSobel, 16'd0, 16'd0, 16'h0001, 16'hFFFF, 0);
        run_frame(ModeRoberts, 16'd300, 16'd1, 16'h8000, 16'h0000, 0);
        run_frame(ModeSobel, 16'h0800, 16'd2, 16'h7FFF, 16'h8000, 0);
        run_frame(ModeRoberts, 16'd1, 16'd200, 16'($urandom), 16'($urandom), 0);
        run_frame(ModeSobel, 16'd3, 16'hFFFF & 16'd40, 16'($urandom), 16'($urandom), 0);

        // Random frames, mostly small.
        while (items_sent < ItemTarget)
        begin
            int w;
            int h;
            w = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
            h = $urandom_range(1, 8);
            run_frame($urandom_range(1), 16'(w), 16'(h), 16'($urandom), 16'($urandom), 0);
        end

        wait (pending_pixels.size() == 0 && !s_axis_tvalid && expected_gradients.size() == 0);
        repeat (SettleTicks) @(posedge clk);
        mismatches += expected_gradients.size();

        $display("%0d frames, %0d items sent, %0d results checked (%0d nodata)",
                 frames_sent, items_sent, results_seen, nodata_seen);
        $display("both operators, size and nodata extremes, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/egm_pkg.sv
rtl/core/egm_ram.sv
rtl/core/egm_front.sv
rtl/core/egm_back.sv
rtl/core/edge_gradient_magnitude_filter.sv
rtl/core/egm_checker.sv
dv/tb_edge_gradient_magnitude_filter.sv
